// ----- rtl/aik_pkg.sv -----
// shared constants, types and the arctangent table of the arm inverse kinematics block
`timescale 1ns / 1ps

package aik_pkg;

  // cordic lane widths
  localparam int CW = 32;           // x and y of a cordic lane
  localparam int AW = 29;           // angle accumulator, 2^-20 degree
  localparam int SW = 31;           // angle sums before rounding
  localparam int TABLE_LEN = 24;

  // square root chain: result bits, operand bits, remainder bits
  localparam int NSQ   = 19;
  localparam int SQ_AW = 2 * NSQ;
  localparam int SQ_RW = NSQ + 3;

  // angles in 2^-20 degree
  localparam logic signed [AW-1:0] DEG90   = 29'sd94371840;
  localparam logic signed [SW-1:0] DEG94P2 = 31'sd98774630;

  // output limits in 1/64 degree
  localparam logic signed [16:0] SH_MIN = -17'sd6000;
  localparam logic signed [16:0] SH_MAX = 17'sd12000;
  localparam logic signed [16:0] EL_MAX = 17'sd17280;

  // configuration register indexes
  typedef enum logic {
    CFG_ARM_LENGTH   = 1'b0,
    CFG_JOINT_HEIGHT = 1'b1
  } cfg_idx_e;

  // side data that travels next to the square root chain
  typedef struct packed {
    logic signed [13:0] x;
    logic signed [13:0] zs;
    logic               hneg;
    logic               hzero;
    logic        [14:0] ah;
    logic               r2nz;
    logic               unreach;
    logic               d2zero;
  } sq_side_t;

  // side data that travels next to the cordic chain
  typedef struct packed {
    logic bzero;
    logic at_frc;
    logic at90;
    logic ac_frc;
    logic ac90;
    logic unreach;
  } co_side_t;

  // atan(2^-i) in 2^-20 degree, rounded to nearest
  function automatic logic [AW-1:0] atan_lut(input int unsigned idx);
    logic [AW-1:0] v;
    case (idx)
      0:       v = 29'd47185920;
      1:       v = 29'd27855475;
      2:       v = 29'd14718068;
      3:       v = 29'd7471121;
      4:       v = 29'd3750058;
      5:       v = 29'd1876857;
      6:       v = 29'd938658;
      7:       v = 29'd469357;
      8:       v = 29'd234682;
      9:       v = 29'd117342;
      10:      v = 29'd58671;
      11:      v = 29'd29335;
      12:      v = 29'd14668;
      13:      v = 29'd7334;
      14:      v = 29'd3667;
      15:      v = 29'd1833;
      16:      v = 29'd917;
      17:      v = 29'd458;
      18:      v = 29'd229;
      19:      v = 29'd115;
      20:      v = 29'd57;
      21:      v = 29'd29;
      22:      v = 29'd14;
      23:      v = 29'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/aik_sqrt_cell.sv -----
// one digit of the pipelined integer square root chain
`timescale 1ns / 1ps

module aik_sqrt_cell import aik_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SQ_RW-1:0] rem_i,
  input  logic [NSQ-1:0]   root_i,
  input  logic [SQ_AW-1:0] arg_i,
  output logic [SQ_RW-1:0] rem_o,
  output logic [NSQ-1:0]   root_o,
  output logic [SQ_AW-1:0] arg_o
);

  logic [SQ_RW-1:0] remx;
  logic [SQ_RW-1:0] trial;
  logic             ge;
  logic [SQ_RW-1:0] rem_d, rem_q;
  logic [NSQ-1:0]   root_d, root_q;
  logic [SQ_AW-1:0] arg_d, arg_q;

  // bring down the next operand pair and try the next root bit
  always_comb begin
    remx   = {rem_i[SQ_RW-3:0], arg_i[SQ_AW-1 -: 2]};
    trial  = {{(SQ_RW-NSQ-2){1'b0}}, root_i, 2'b01};
    ge     = (remx >= trial);
    rem_d  = ge ? (remx - trial) : remx;
    root_d = {root_i[NSQ-2:0], ge};
    arg_d  = {arg_i[SQ_AW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      arg_q  <= arg_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign arg_o  = arg_q;

endmodule

// ----- rtl/aik_cordic_cell.sv -----
// one micro-rotation of a vectoring cordic chain
`timescale 1ns / 1ps

module aik_cordic_cell import aik_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [AW-1:0] ang_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [AW-1:0] ang_o
);

  localparam logic signed [AW-1:0] STEP = $signed(atan_lut(STAGE));

  logic signed [CW-1:0] x_d, x_q, y_d, y_q;
  logic signed [AW-1:0] a_d, a_q;

  // rotate toward the x axis
  always_comb begin
    if (y_i >= 0) begin
      x_d = x_i + (y_i >>> STAGE);
      y_d = y_i - (x_i >>> STAGE);
      a_d = ang_i + STEP;
    end else begin
      x_d = x_i - (y_i >>> STAGE);
      y_d = y_i + (x_i >>> STAGE);
      a_d = ang_i - STEP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      a_q <= a_d;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign ang_o = a_q;

endmodule

// ----- rtl/arm_inverse_kinematics_top.sv -----
// arm inverse kinematics: target point in, base, shoulder and elbow angles out
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------------
//  in       | in_valid_i / in_ready_o | x_pos_i, y_pos_i, z_pos_i
//  out      | out_valid_o/out_ready_i | base_angle_o, shoulder_angle_o, elbow_angle_o,
//           |                         | unreachable_o
//  config   | cfg_we_i                | cfg_idx_i, cfg_data_i
//
//  one item per cycle while the row of cells is not stalled; an item passes six front stages
//  (z scaling, squares, sums, reach test), 19 square root cells, the cordic cells
//  and the output register.
//  reset clears the valid line and the output register flag and loads the default configuration.
//  the whole row of cells stalls only when the last cell and the output register
//  both hold an item that the output side does not take; bubbles keep input open.
`timescale 1ns / 1ps

module arm_inverse_kinematics_top import aik_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic        [13:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [13:0] x_pos_i,
  input  logic signed [13:0] y_pos_i,
  input  logic signed [13:0] z_pos_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] base_angle_o,
  output logic signed [14:0] shoulder_angle_o,
  output logic        [14:0] elbow_angle_o,
  output logic               unreachable_o
);

  localparam int DEPTH = 6 + NSQ + CORDIC_STAGES;

  // configuration registers
  logic        [12:0] arm_len_q;
  logic signed [13:0] jh_q;
  logic        [25:0] l2;
  logic        [27:0] fl2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_len_q <= 13'd1600;
      jh_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ARM_LENGTH:   arm_len_q <= cfg_data_i[12:0];
        CFG_JOINT_HEIGHT: jh_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // reach limit 4*L^2
  assign l2 = arm_len_q * arm_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl2_q <= 28'd10240000;
    end else begin
      fl2_q <= {l2, 2'b00};
    end
  end

  // pipeline flow control
  logic             en;
  logic [DEPTH-1:0] vld_q;
  logic             last_vld;
  logic             ov_q;

  assign last_vld   = vld_q[DEPTH-1];
  assign en         = !(last_vld && ov_q && !out_ready_i);
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
      end
      if (last_vld && en) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // front stages
  logic signed [13:0] x_a, y_a, z_a;
  logic signed [14:0] zx, az;
  logic        [17:0] n_d, n_b;
  logic        [33:0] prod_d, prod_b;
  logic               zneg_b;
  logic signed [13:0] x_b;
  logic signed [14:0] h_d, h_b;
  logic        [13:0] q0;
  logic        [17:0] rem;
  logic        [13:0] zmag;
  logic signed [13:0] zs_d, x_c, zs_c;
  logic signed [14:0] h_c;
  logic signed [27:0] xxs, zzs;
  logic signed [29:0] hhs;
  logic        [26:0] xx_d;
  logic        [25:0] zz_d;
  logic        [27:0] hh_d;
  logic signed [13:0] x_d4, zs_d4;
  logic signed [14:0] h_d4;
  logic        [26:0] r2_e;
  logic        [28:0] d2_e;
  logic signed [13:0] x_e, zs_e;
  logic signed [14:0] h_e;

  always_comb begin
    // stage b: z magnitude times 20/22 by reciprocal
    zx     = {z_a[13], z_a};
    az     = (zx < 0) ? -zx : zx;
    n_d    = {3'b000, az} * 18'd20 + 18'd11;
    prod_d = {16'd0, n_d} * 34'd47662;
    h_d    = {jh_q[13], jh_q} - {y_a[13], y_a};
    // stage c: one correction step of the quotient
    q0     = prod_b[33:20];
    rem    = n_b - {4'd0, q0} * 18'd22;
    zmag   = (rem >= 18'd22) ? (q0 + 14'd1) : q0;
    zs_d   = zneg_b ? -$signed(zmag) : $signed(zmag);
    // stage d: squares
    xxs    = x_c * x_c;
    zzs    = zs_c * zs_c;
    hhs    = h_c * h_c;
    xx_d   = xxs[26:0];
    zz_d   = zzs[25:0];
    hh_d   = hhs[27:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_a    <= x_pos_i;
      y_a    <= y_pos_i;
      z_a    <= z_pos_i;
      n_b    <= n_d;
      prod_b <= prod_d;
      zneg_b <= z_a[13];
      x_b    <= x_a;
      h_b    <= h_d;
      x_c    <= x_b;
      zs_c   <= zs_d;
      h_c    <= h_b;
      x_d4   <= x_c;
      zs_d4  <= zs_c;
      h_d4   <= h_c;
    end
  end

  // stage e: sums of squares
  logic [26:0] xx_q, zz_q_ext;
  logic [25:0] zz_q;
  logic [27:0] hh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q <= xx_d;
      zz_q <= zz_d;
      hh_q <= hh_d;
    end
  end

  assign zz_q_ext = {1'b0, zz_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_e <= xx_q + zz_q_ext;
      d2_e <= {2'b00, xx_q} + {2'b00, zz_q_ext} + {1'b0, hh_q};
      x_e  <= x_d4;
      zs_e <= zs_d4;
      h_e  <= h_d4;
    end
  end

  // stage f: reach test and square root operands
  logic        [27:0]    diff;
  logic signed [14:0]    h_abs;
  sq_side_t              side_f;
  logic [SQ_AW-1:0]      arg_f [3];
  logic [SQ_AW-1:0]      argf_q [3];

  always_comb begin
    diff           = fl2_q - d2_e[27:0];
    h_abs          = (h_e < 0) ? -h_e : h_e;
    side_f.x       = x_e;
    side_f.zs      = zs_e;
    side_f.hneg    = (h_e < 0);
    side_f.hzero   = (h_e == 15'sd0);
    side_f.ah      = h_abs;
    side_f.r2nz    = (r2_e != 27'd0);
    side_f.unreach = (d2_e > {1'b0, fl2_q});
    side_f.d2zero  = (d2_e == 29'd0);
    arg_f[0]       = {3'b000, r2_e, 8'h00};
    arg_f[1]       = {1'b0, d2_e, 8'h00};
    arg_f[2]       = {2'b00, diff, 8'h00};
  end

  // square root chains: r, d and the acos leg s
  logic [SQ_RW-1:0] sq_rem  [3][NSQ+1];
  logic [NSQ-1:0]   sq_root [3][NSQ+1];
  logic [SQ_AW-1:0] sq_arg  [3][NSQ+1];
  sq_side_t         sside_q [NSQ+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        argf_q[l] <= arg_f[l];
      end
      sside_q[0] <= side_f;
      for (int j = 1; j <= NSQ; j++) begin
        sside_q[j] <= sside_q[j-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_sq_lane
    assign sq_rem[l][0]  = '0;
    assign sq_root[l][0] = '0;
    assign sq_arg[l][0]  = argf_q[l];
    for (genvar j = 0; j < NSQ; j++) begin : g_sq_cell
      aik_sqrt_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .rem_i  (sq_rem[l][j]),
        .root_i (sq_root[l][j]),
        .arg_i  (sq_arg[l][j]),
        .rem_o  (sq_rem[l][j+1]),
        .root_o (sq_root[l][j+1]),
        .arg_o  (sq_arg[l][j+1])
      );
    end
  end

  // cordic entry: base, atan and acos lanes
  sq_side_t             ss;
  logic signed [CW-1:0] bx, by, rf256, df256, sf256, ah4096;
  logic signed [CW-1:0] co_x   [3][CORDIC_STAGES+1];
  logic signed [CW-1:0] co_y   [3][CORDIC_STAGES+1];
  logic signed [AW-1:0] co_a   [3][CORDIC_STAGES+1];
  co_side_t             cside_d;
  co_side_t             cside_q [CORDIC_STAGES];

  always_comb begin
    ss     = sside_q[NSQ];
    bx     = {{10{ss.x[13]}}, ss.x, 8'h00};
    by     = {{10{ss.zs[13]}}, ss.zs, 8'h00};
    rf256  = {5'd0, sq_root[0][NSQ], 8'h00};
    df256  = {5'd0, sq_root[1][NSQ], 8'h00};
    sf256  = {5'd0, sq_root[2][NSQ], 8'h00};
    ah4096 = {5'd0, ss.ah, 12'h000};
    // base: fold the left half plane onto the right one
    if (bx < 0) begin
      if (by >= 0) begin
        co_x[0][0] = by;
        co_y[0][0] = -bx;
        co_a[0][0] = DEG90;
      end else begin
        co_x[0][0] = -by;
        co_y[0][0] = bx;
        co_a[0][0] = -DEG90;
      end
    end else begin
      co_x[0][0] = bx;
      co_y[0][0] = by;
      co_a[0][0] = '0;
    end
    // atan(r/h), sign of h moves onto the y leg
    co_x[1][0] = ah4096;
    co_y[1][0] = ss.hneg ? -rf256 : rf256;
    co_a[1][0] = '0;
    // acos(d/2L) as atan2(s, d)
    co_x[2][0] = df256;
    co_y[2][0] = sf256;
    co_a[2][0] = '0;
    cside_d.bzero   = (ss.x == 14'sd0) && (ss.zs == 14'sd0);
    cside_d.at_frc  = ss.hzero;
    cside_d.at90    = ss.r2nz;
    cside_d.ac_frc  = ss.unreach || ss.d2zero;
    cside_d.ac90    = !ss.unreach;
    cside_d.unreach = ss.unreach;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cside_q[0] <= cside_d;
      for (int k = 1; k < CORDIC_STAGES; k++) begin
        cside_q[k] <= cside_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_co_lane
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_co_cell
      aik_cordic_cell #(
        .STAGE (k)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (co_x[l][k]),
        .y_i   (co_y[l][k]),
        .ang_i (co_a[l][k]),
        .x_o   (co_x[l][k+1]),
        .y_o   (co_y[l][k+1]),
        .ang_o (co_a[l][k+1])
      );
    end
  end

  // final angles, rounding to 1/64 degree and limits
  co_side_t             cs;
  logic signed [SW-1:0] base_w, at_w, ac_w, sh_w, el_w;
  logic signed [16:0]   base64, sh64, el64;
  logic signed [14:0]   base_d, sh_d;
  logic        [14:0]   el_d;
  logic signed [14:0]   base_q, sh_q;
  logic        [14:0]   el_q;
  logic                 unr_q;

  always_comb begin
    cs     = cside_q[CORDIC_STAGES-1];
    base_w = cs.bzero ? '0 : SW'(co_a[0][CORDIC_STAGES]);
    if (cs.at_frc) begin
      at_w = cs.at90 ? SW'(DEG90) : '0;
    end else begin
      at_w = SW'(co_a[1][CORDIC_STAGES]);
    end
    if (cs.ac_frc) begin
      ac_w = cs.ac90 ? SW'(DEG90) : '0;
    end else begin
      ac_w = SW'(co_a[2][CORDIC_STAGES]);
    end
    sh_w   = DEG94P2 - at_w - ac_w;
    el_w   = SW'(DEG90) - at_w + ac_w;
    base64 = 17'((base_w + 31'sd8192) >>> 14);
    sh64   = 17'((sh_w + 31'sd8192) >>> 14);
    el64   = 17'((el_w + 31'sd8192) >>> 14);
    base_d = base64[14:0];
    if (sh64 < SH_MIN) begin
      sh_d = SH_MIN[14:0];
    end else if (sh64 > SH_MAX) begin
      sh_d = SH_MAX[14:0];
    end else begin
      sh_d = sh64[14:0];
    end
    if (el64 < 0) begin
      el_d = '0;
    end else if (el64 > EL_MAX) begin
      el_d = EL_MAX[14:0];
    end else begin
      el_d = el64[14:0];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (last_vld && en) begin
      base_q <= base_d;
      sh_q   <= sh_d;
      el_q   <= el_d;
      unr_q  <= cs.unreach;
    end
  end

  assign out_valid_o      = ov_q;
  assign base_angle_o     = base_q;
  assign shoulder_angle_o = sh_q;
  assign elbow_angle_o    = el_q;
  assign unreachable_o    = unr_q;

endmodule

// ----- rtl/aik_checker.sv -----
// port checker for the arm inverse kinematics block and its bind
`timescale 1ns / 1ps

module aik_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic               cfg_idx_i,
  input logic        [13:0] cfg_data_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic signed [13:0] x_pos_i,
  input logic signed [13:0] y_pos_i,
  input logic signed [13:0] z_pos_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [14:0] base_angle_o,
  input logic signed [14:0] shoulder_angle_o,
  input logic        [14:0] elbow_angle_o,
  input logic               unreachable_o
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // a waiting result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(base_angle_o) && $stable(shoulder_angle_o)
      && $stable(elbow_angle_o) && $stable(unreachable_o))
    else $error("result payload changed while stalled");

  // input is held off only by a full and stalled output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back pressure");

  // joint angles stay inside their limits
  a_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shoulder_angle_o >= -15'sd6000 && shoulder_angle_o <= 15'sd12000
      && elbow_angle_o <= 15'd17280)
    else $error("joint angle outside its limits");

endmodule

bind arm_inverse_kinematics_top aik_checker u_aik_checker (.*);
